/* rtl/region_table_access_check_macros.svh */
// Assertion macros for the region table access check.
`ifndef REGION_TABLE_ACCESS_CHECK_MACROS_SVH
`define REGION_TABLE_ACCESS_CHECK_MACROS_SVH

// Checked at every edge outside reset.
`define RTAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rtac_pkg.sv */
package rtac_pkg;

  localparam int DEFAULT_REGIONS = 16;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_UNMAPPED = 2'd1,
    FAULT_DENIED   = 2'd2,
    FAULT_RANGE    = 2'd3
  } fault_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [63:0] entry_base;
    logic [63:0] entry_length;
    logic [31:0] entry_physical;
    logic [7:0]  entry_rights;
    logic [63:0] access_address;
    logic [63:0] access_length;
    logic [7:0]  access_rights;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  fault_code;
    logic [63:0] run_base;
    logic [31:0] run_physical;
    logic [63:0] run_length;
    logic [7:0]  found_rights;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] physical;
    logic [7:0]  rights;
  } region_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_BACK,
    ST_FWD,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic start_scan;
    logic check;
    logic start_back;
    logic start_fwd;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic check_ok;
    logic found_first;
    logic found_last;
  } sts_t;

endpackage

/* rtl/rtac_ram.sv */
module rtac_ram #(
  parameter int WIDTH = $bits(rtac_pkg::region_entry_t),
  parameter int DEPTH = rtac_pkg::DEFAULT_REGIONS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rtac_ctrl.sv */
module rtac_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  output logic           out_valid,
  input  logic           out_ready,
  output rtac_pkg::cmd_t cmd,
  input  rtac_pkg::sts_t sts
);

  rtac_pkg::state_t state;
  rtac_pkg::state_t state_next;
  logic             out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_out) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rtac_pkg::ST_IDLE: begin
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            if (func == rtac_pkg::FUNC_WRITE) begin
              state_next = rtac_pkg::ST_DONE;
            end else begin
              cmd.start_scan = 1'b1;
              state_next     = rtac_pkg::ST_SCAN;
            end
          end
        end
      end
      rtac_pkg::ST_SCAN: begin
        if (sts.walk_done) begin
          state_next = rtac_pkg::ST_CHECK;
        end
      end
      rtac_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (!sts.check_ok) begin
          state_next = rtac_pkg::ST_DONE;
        end else if (!sts.found_first) begin
          cmd.start_back = 1'b1;
          state_next     = rtac_pkg::ST_BACK;
        end else if (!sts.found_last) begin
          cmd.start_fwd = 1'b1;
          state_next    = rtac_pkg::ST_FWD;
        end else begin
          state_next = rtac_pkg::ST_FINAL;
        end
      end
      rtac_pkg::ST_BACK: begin
        if (sts.walk_done) begin
          if (!sts.found_last) begin
            cmd.start_fwd = 1'b1;
            state_next    = rtac_pkg::ST_FWD;
          end else begin
            state_next = rtac_pkg::ST_FINAL;
          end
        end
      end
      rtac_pkg::ST_FWD: begin
        if (sts.walk_done) begin
          state_next = rtac_pkg::ST_FINAL;
        end
      end
      rtac_pkg::ST_FINAL: begin
        cmd.finish = 1'b1;
        state_next = rtac_pkg::ST_DONE;
      end
      rtac_pkg::ST_DONE: begin
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = rtac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtac_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rtac_dp.sv */
module rtac_dp #(
  parameter int REGIONS = rtac_pkg::DEFAULT_REGIONS
) (
  input  logic                clk,
  input  logic                rst,
  input  rtac_pkg::cmd_t      cmd,
  output rtac_pkg::sts_t      sts,
  input  rtac_pkg::in_item_t  in_data,
  output rtac_pkg::out_item_t out_data
);

  localparam int IW = $clog2(REGIONS);
  localparam logic [IW-1:0] LAST = IW'(REGIONS - 1);

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_BACK,
    MODE_FWD
  } walk_mode_t;

  rtac_pkg::in_item_t     item;
  rtac_pkg::region_entry_t rd;
  rtac_pkg::region_entry_t wr_entry;
  rtac_pkg::region_entry_t found_entry;
  rtac_pkg::out_item_t    res;

  logic [REGIONS-1:0] valid;
  logic               we;
  logic [IW-1:0]      waddr;

  walk_mode_t    mode;
  logic          issue_live;
  logic [IW-1:0] issue_idx;
  logic [IW-1:0] end_idx;
  logic          ev_on;
  logic [IW-1:0] ev_idx;
  logic          start_any;

  logic          have;
  logic [IW-1:0] found_idx;
  logic [63:0]   run_base;
  logic [31:0]   run_phys;
  logic [64:0]   run_end;
  logic [64:0]   acc_end;

  logic        ev_valid;
  logic        grant_rd;
  logic [64:0] rd_end;
  logic        stop;
  logic        last;
  logic        done;
  logic        advance;
  logic        contains;
  logic        grant_found;
  logic [63:0] diff;
  logic        saturate;
  logic        cover_fail;

  assign we    = cmd.capture && (in_data.func == rtac_pkg::FUNC_WRITE) &&
                 (int'(in_data.entry_index) < REGIONS);
  assign waddr = IW'(in_data.entry_index);

  assign wr_entry.base     = in_data.entry_base;
  assign wr_entry.length   = in_data.entry_length;
  assign wr_entry.physical = in_data.entry_physical;
  assign wr_entry.rights   = in_data.entry_rights;

  rtac_ram #(
    .WIDTH($bits(rtac_pkg::region_entry_t)),
    .DEPTH(REGIONS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_entry),
    .raddr(issue_idx),
    .rdata(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= in_data.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    acc_end <= {1'b0, item.access_address} + {1'b0, item.access_length};
  end

  // Each walk reads one entry per cycle and judges it in the cycle after the read.
  assign ev_valid = valid[ev_idx];
  assign grant_rd = (rd.rights & item.access_rights) == item.access_rights;
  assign rd_end   = {1'b0, rd.base} + {1'b0, rd.length};
  assign last     = ev_idx == end_idx;

  always_comb begin
    stop = 1'b0;
    case (mode)
      MODE_BACK: stop = ev_valid && (rd_end[64] || rd_end[63:0] != run_base || !grant_rd);
      MODE_FWD:  stop = ev_valid && (run_end[64] || run_end[63:0] != rd.base || !grant_rd);
      default:   stop = 1'b0;
    endcase
  end

  assign done      = ev_on && (stop || last);
  assign advance   = ev_on && ev_valid && !stop;
  assign start_any = cmd.start_scan || cmd.start_back || cmd.start_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_live <= 1'b0;
      ev_on      <= 1'b0;
    end else if (start_any) begin
      issue_live <= 1'b1;
      ev_on      <= 1'b0;
    end else if (done) begin
      issue_live <= 1'b0;
      ev_on      <= 1'b0;
    end else begin
      ev_on <= issue_live;
      if (issue_live && issue_idx == end_idx) begin
        issue_live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= issue_idx;
    if (cmd.start_scan) begin
      mode      <= MODE_SCAN;
      issue_idx <= '0;
      end_idx   <= LAST;
    end else if (cmd.start_back) begin
      mode      <= MODE_BACK;
      issue_idx <= found_idx - 1'b1;
      end_idx   <= '0;
    end else if (cmd.start_fwd) begin
      mode      <= MODE_FWD;
      issue_idx <= found_idx + 1'b1;
      end_idx   <= LAST;
    end else if (issue_live && issue_idx != end_idx) begin
      if (mode == MODE_BACK) begin
        issue_idx <= issue_idx - 1'b1;
      end else begin
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.start_scan) begin
      have <= 1'b0;
    end else if (advance && mode == MODE_SCAN && rd.base <= item.access_address) begin
      have <= 1'b1;
    end
  end

  assign contains    = have && (item.access_address - found_entry.base) < found_entry.length;
  assign grant_found = (found_entry.rights & item.access_rights) == item.access_rights;

  assign diff       = run_end[63:0] - run_base;
  assign saturate   = run_end[64] && (run_end[63:0] >= run_base);
  assign cover_fail = (item.access_length != '0) && (run_end < acc_end);

  always_ff @(posedge clk) begin
    if (advance && mode == MODE_SCAN && rd.base <= item.access_address) begin
      found_idx   <= ev_idx;
      found_entry <= rd;
    end
    if (cmd.check) begin
      run_base <= found_entry.base;
      run_phys <= found_entry.physical;
      run_end  <= {1'b0, found_entry.base} + {1'b0, found_entry.length};
    end else if (advance && mode == MODE_BACK) begin
      run_base <= rd.base;
      run_phys <= rd.physical;
    end else if (advance && mode == MODE_FWD) begin
      run_end <= run_end + {1'b0, rd.length};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res <= '0;
    end else if (cmd.check && !contains) begin
      res.fault_code <= rtac_pkg::FAULT_UNMAPPED;
    end else if (cmd.check && !grant_found) begin
      res.fault_code   <= rtac_pkg::FAULT_DENIED;
      res.found_rights <= found_entry.rights;
    end else if (cmd.finish) begin
      res.fault_code   <= cover_fail ? rtac_pkg::FAULT_RANGE : rtac_pkg::FAULT_NONE;
      res.run_base     <= run_base;
      res.run_physical <= run_phys;
      res.run_length   <= saturate ? '1 : diff;
      res.found_rights <= found_entry.rights;
    end
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  assign sts.walk_done   = done;
  assign sts.check_ok    = contains && grant_found;
  assign sts.found_first = found_idx == '0;
  assign sts.found_last  = found_idx == LAST;

endmodule

/* rtl/region_table_access_check.sv */
// Region table with an access check. A write beat stores one table slot and
// answers with an all-zero result. A lookup walks the table through its read
// port one slot per cycle: a full scan to find the containing region, a check
// step, then, if the check passes, a backward merge and a forward merge (each
// skipped at that end of the table) and a finishing step. One item is worked
// on at a time; the next beat is taken while a finished result still waits in
// the output register. Slot valid bits clear at reset, so no clearing pass is
// needed.
module region_table_access_check #(
  parameter int REGIONS = rtac_pkg::DEFAULT_REGIONS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtac_pkg::out_item_t out_data
);

  rtac_pkg::cmd_t cmd;
  rtac_pkg::sts_t sts;

  rtac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (in_data.func),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rtac_dp #(
    .REGIONS(REGIONS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_data (in_data),
    .out_data(out_data)
  );

endmodule

/* rtl/rtac_checker.sv */
`include "region_table_access_check_macros.svh"

module rtac_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rtac_pkg::out_item_t out_data
);

  `RTAC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `RTAC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `RTAC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "second beat taken while busy")
  `RTAC_ASSERT(a_unmapped_zero, out_valid && out_data.fault_code == rtac_pkg::FAULT_UNMAPPED |-> out_data.run_base == '0 && out_data.run_length == '0 && out_data.run_physical == '0 && out_data.found_rights == '0, "unmapped result carries data")
  `RTAC_ASSERT(a_denied_no_run, out_valid && out_data.fault_code == rtac_pkg::FAULT_DENIED |-> out_data.run_base == '0 && out_data.run_length == '0 && out_data.run_physical == '0, "denied result carries a run")

endmodule

bind region_table_access_check rtac_checker u_checker (.*);

/* tb/region_table_access_check_test.sv */
`timescale 1ns / 1ps

module region_table_access_check_test;

  localparam int SLOTS = rtac_pkg::DEFAULT_REGIONS;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  rtac_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rtac_pkg::out_item_t out_data;

  logic [63:0] tbl_base [SLOTS];
  logic [63:0] tbl_length [SLOTS];
  logic [31:0] tbl_phys [SLOTS];
  logic [7:0]  tbl_rights [SLOTS];
  bit          tbl_valid [SLOTS];

  rtac_pkg::out_item_t expected_results [$];
  int errors = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  region_table_access_check i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic rtac_pkg::out_item_t predict_access(rtac_pkg::in_item_t item);
    rtac_pkg::out_item_t res;
    int          found;
    int          cur;
    int          j;
    bit          have;
    bit          stop;
    logic [64:0] run_end;
    logic [64:0] prev_end;
    logic [64:0] acc_end;
    logic [64:0] span;
    logic [63:0] run_base;
    logic [31:0] run_phys;
    logic [7:0]  req;
    res = '0;
    req = item.access_rights;
    if (item.func == rtac_pkg::FUNC_WRITE) begin
      tbl_valid[item.entry_index] = item.entry_valid;
      tbl_base[item.entry_index] = item.entry_base;
      tbl_length[item.entry_index] = item.entry_length;
      tbl_phys[item.entry_index] = item.entry_physical;
      tbl_rights[item.entry_index] = item.entry_rights;
      return res;
    end
    found = 0;
    have = 1'b0;
    for (j = 0; j < SLOTS; j++) begin
      if (tbl_valid[j] && tbl_base[j] <= item.access_address) begin
        found = j;
        have = 1'b1;
      end
    end
    if (!have || item.access_address - tbl_base[found] >= tbl_length[found]) begin
      res.fault_code = rtac_pkg::FAULT_UNMAPPED;
      return res;
    end
    if ((tbl_rights[found] & req) != req) begin
      res.fault_code = rtac_pkg::FAULT_DENIED;
      res.found_rights = tbl_rights[found];
      return res;
    end
    run_base = tbl_base[found];
    run_phys = tbl_phys[found];
    run_end = {1'b0, tbl_base[found]} + {1'b0, tbl_length[found]};
    cur = found;
    stop = 1'b0;
    for (j = found - 1; j >= 0 && !stop; j--) begin
      if (tbl_valid[j]) begin
        prev_end = {1'b0, tbl_base[j]} + {1'b0, tbl_length[j]};
        if (prev_end != {1'b0, tbl_base[cur]} || (tbl_rights[j] & req) != req) begin
          stop = 1'b1;
        end else begin
          run_base = tbl_base[j];
          run_phys = tbl_phys[j];
          cur = j;
        end
      end
    end
    stop = 1'b0;
    for (j = found + 1; j < SLOTS && !stop; j++) begin
      if (tbl_valid[j]) begin
        if (run_end != {1'b0, tbl_base[j]} || (tbl_rights[j] & req) != req) begin
          stop = 1'b1;
        end else begin
          run_end = run_end + {1'b0, tbl_length[j]};
        end
      end
    end
    span = run_end - {1'b0, run_base};
    res.run_base = run_base;
    res.run_physical = run_phys;
    res.run_length = span[64] ? 64'hFFFF_FFFF_FFFF_FFFF : span[63:0];
    res.found_rights = tbl_rights[found];
    acc_end = {1'b0, item.access_address} + {1'b0, item.access_length};
    if (item.access_length != 0 && run_end < acc_end) begin
      res.fault_code = rtac_pkg::FAULT_RANGE;
    end
    return res;
  endfunction

  function automatic rtac_pkg::in_item_t random_item();
    rtac_pkg::in_item_t item;
    item.func = 1'($urandom_range(0, 1));
    item.entry_index = 4'($urandom);
    item.entry_valid = 1'($urandom_range(0, 1));
    item.entry_base = rand64();
    item.entry_length = rand64();
    item.entry_physical = $urandom;
    item.entry_rights = 8'($urandom);
    item.access_address = rand64();
    item.access_length = rand64();
    item.access_rights = 8'($urandom);
    return item;
  endfunction

  task automatic send_beat(rtac_pkg::in_item_t item);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_access(item));
  endtask

  task automatic write_slot(logic [3:0] idx, logic valid, logic [63:0] base,
                            logic [63:0] len, logic [31:0] phys, logic [7:0] rights);
    rtac_pkg::in_item_t item;
    item = random_item();
    item.func = rtac_pkg::FUNC_WRITE;
    item.entry_index = idx;
    item.entry_valid = valid;
    item.entry_base = base;
    item.entry_length = len;
    item.entry_physical = phys;
    item.entry_rights = rights;
    send_beat(item);
  endtask

  task automatic lookup(logic [63:0] addr, logic [63:0] len, logic [7:0] rights);
    rtac_pkg::in_item_t item;
    item = random_item();
    item.func = rtac_pkg::FUNC_LOOKUP;
    item.access_address = addr;
    item.access_length = len;
    item.access_rights = rights;
    send_beat(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 15))
      0: return rand64();
      1: return 64'h0;
      2: return rand64() >> $urandom_range(8, 40);
      default: return 64'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [7:0] pick_rights(logic [7:0] common);
    if ($urandom_range(0, 5) == 0) begin
      return 8'($urandom);
    end
    return common | 8'($urandom & $urandom);
  endfunction

  task automatic lookup_somewhere(logic [7:0] common);
    int          slot;
    int          tries;
    logic [63:0] addr;
    logic [63:0] len;
    logic [7:0]  rights;
    slot = -1;
    for (tries = 0; tries < 8 && slot < 0; tries++) begin
      slot = $urandom_range(0, SLOTS - 1);
      if (!tbl_valid[slot]) begin
        slot = -1;
      end
    end
    if (slot < 0) begin
      addr = rand64();
    end else begin
      case ($urandom_range(0, 9))
        0: addr = rand64();
        1: addr = tbl_base[slot] - 64'd1;
        2: addr = tbl_base[slot] + tbl_length[slot];
        default: begin
          addr = tbl_base[slot];
          if (tbl_length[slot] != 0) begin
            addr = tbl_base[slot] + rand64() % tbl_length[slot];
          end
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1: len = 64'h0;
      2: len = rand64();
      3: len = (slot < 0) ? 64'h1 : tbl_base[slot] + tbl_length[slot] - addr;
      default: len = 64'($urandom_range(1, 8192));
    endcase
    case ($urandom_range(0, 9))
      0: rights = 8'h00;
      1, 2: rights = 8'($urandom);
      default: rights = common & 8'($urandom);
    endcase
    lookup(addr, len, rights);
  endtask

  task automatic run_table_phase(int lookups);
    logic [63:0] base;
    logic [63:0] len;
    logic [7:0]  common;
    int          used;
    common = 8'($urandom);
    used = $urandom_range(1, SLOTS);
    if ($urandom_range(0, 7) == 0) begin
      base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40000));
    end else begin
      base = rand64() >> $urandom_range(0, 40);
    end
    for (int i = 0; i < SLOTS; i++) begin
      len = pick_length();
      write_slot(4'(i), i < used && $urandom_range(0, 9) != 0, base, len, $urandom,
                 pick_rights(common));
      base = base + len + 64'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : 0);
    end
    for (int n = 0; n < lookups; n++) begin
      lookup_somewhere(common);
    end
  endtask

  task automatic test_directed();
    lookup(64'h0, 64'h0, 8'h00);
    write_slot(4'd0, 1'b1, 64'h1000, 64'h1000, 32'h0001_0000, 8'h07);
    write_slot(4'd1, 1'b1, 64'h2000, 64'h1000, 32'h0002_0000, 8'h03);
    write_slot(4'd2, 1'b1, 64'h3000, 64'h1000, 32'h0003_0000, 8'h07);
    write_slot(4'd3, 1'b1, 64'h5000, 64'h0100, 32'h0000_0000, 8'hFF);
    lookup(64'h3800, 64'h0, 8'h03);
    lookup(64'h2400, 64'h10, 8'h04);
    lookup(64'h1000, 64'h3000, 8'h03);
    lookup(64'h1000, 64'h3001, 8'h03);
    lookup(64'h4800, 64'h1, 8'h01);
    write_slot(4'd2, 1'b0, 64'h3000, 64'h1000, 32'h0003_0000, 8'h07);
    lookup(64'h3800, 64'h1, 8'h01);
    lookup(64'h1800, 64'h0, 8'h00);
    write_slot(4'd4, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 32'hFFFF_FFFF, 8'hFF);
    lookup(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'hFF);
    lookup(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    write_slot(4'd5, 1'b1, 64'h100, 64'h100, 32'h1234_5678, 8'h80);
    lookup(64'h150, 64'h100, 8'h80);
    write_slot(4'd15, 1'b0, '1, '1, '1, '1);
    write_slot(4'd0, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 32'h0, 8'hFF);
    write_slot(4'd1, 1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
               32'h8000_0000, 8'hFF);
    write_slot(4'd3, 1'b0, 64'h0, 64'h0, 32'h0, 8'h00);
    write_slot(4'd4, 1'b0, 64'h0, 64'h0, 32'h0, 8'h00);
    write_slot(4'd5, 1'b0, 64'h0, 64'h0, 32'h0, 8'h00);
    lookup(64'h8000_0000_0000_0005, 64'h7FFF_FFFF_FFFF_FFFB, 8'hFF);
  endtask

  task automatic test_random_tables();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int p = 0; p < 17; p++) begin
      run_table_phase(48);
    end
  endtask

  task automatic test_noise();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int n = 0; n < 80; n++) begin
      send_beat(random_item());
    end
  endtask

  // The receiver holds off while writes and lookups are offered, so the block
  // stalls them, then the sender waits until every outstanding result has been returned.
  task automatic test_fill_and_drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_seq++;
    run_table_phase(24);
    drain();
  endtask

  task automatic test_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_table_phase(24);
    run_table_phase(24);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rtac_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: %p", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("fault_code", 64'(want.fault_code), 64'(out_data.fault_code));
        compare_field("run_base", want.run_base, out_data.run_base);
        compare_field("run_physical", 64'(want.run_physical), 64'(out_data.run_physical));
        compare_field("run_length", want.run_length, out_data.run_length);
        compare_field("found_rights", 64'(want.found_rights), 64'(out_data.found_rights));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    foreach (tbl_valid[k]) begin
      tbl_valid[k] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_random_tables();
    test_noise();
    drain();
    test_fill_and_drain();
    test_streaming();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rtac_pkg.sv
rtl/rtac_ram.sv
rtl/rtac_ctrl.sv
rtl/rtac_dp.sv
rtl/region_table_access_check.sv
rtl/rtac_checker.sv
tb/region_table_access_check_test.sv
